/* rtl/rlpc_pkg.sv */
// Package: types, keyword tables and codes for the request line classifier.
`default_nettype none
package rlpc_pkg;

	localparam int unsigned NUM_METHODS      = 18;
	localparam int unsigned NUM_RTSP_METHODS = 12;
	localparam int unsigned NUM_PREFIXES     = 5;
	localparam int unsigned METHOD_BYTES     = 13;
	localparam int unsigned PREFIX_BYTES     = 7;
	localparam int unsigned WINDOW_BYTES     = 5;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] category_t;
	typedef logic [1:0] count_t;
	typedef logic [4:0] pos_t;

	localparam category_t CAT_UNKNOWN = 3'd0;
	localparam category_t CAT_HTTP    = 3'd1;
	localparam category_t CAT_HLS     = 3'd2;
	localparam category_t CAT_RTSP    = 3'd3;
	localparam category_t CAT_REVERSE = 3'd4;

	localparam pos_t POS_MAX = 5'd31;
	localparam count_t TOKENS_MAX = 2'd3;

	// Verdict flag positions
	localparam int unsigned V_RTSP_METHOD = 0;
	localparam int unsigned V_HTTP_METHOD = 1;
	localparam int unsigned V_REVERSE     = 2;
	localparam int unsigned V_RTSP_URL    = 3;
	localparam int unsigned V_HLS         = 4;
	localparam int unsigned V_VER_RTSP    = 5;
	localparam int unsigned V_VER_HTTP    = 6;
	localparam int unsigned NUM_VERDICTS  = 7;

	// Prefix slots
	localparam int unsigned P_MTH_HTTP  = 0;
	localparam int unsigned P_MTH_EVENT = 1;
	localparam int unsigned P_URL_RTSP  = 2;
	localparam int unsigned P_VER_RTSP  = 3;
	localparam int unsigned P_VER_HTTP  = 4;

	localparam byte_t CH_CR  = 8'h0D;
	localparam byte_t CH_LF  = 8'h0A;
	localparam byte_t CH_SP  = 8'h20;
	localparam byte_t CH_TAB = 8'h09;
	localparam byte_t CH_VT  = 8'h0B;
	localparam byte_t CH_FF  = 8'h0C;
	localparam byte_t CH_QM  = 8'h3F;
	localparam byte_t CH_HASH = 8'h23;

	localparam logic [NUM_METHODS-1:0] HTTP_METHOD_MASK = 18'h3F010;

	// Strings are right-justified: byte p of an n-byte name sits at lane n-1-p
	localparam logic [8*METHOD_BYTES-1:0] METHOD_NAME [NUM_METHODS] = '{
		"ANNOUNCE", "DESCRIBE", "FLUSH", "GET\137PARAMETER", "OPTIONS", "PAUSE",
		"PLAY", "RECORD", "REDIRECT", "SET\137PARAMETER", "SETUP", "TEARDOWN",
		"DELETE", "GET", "HEAD", "PATCH", "POST", "PUT"
	};
	localparam pos_t METHOD_LEN [NUM_METHODS] = '{
		5'd8, 5'd8, 5'd5, 5'd13, 5'd7, 5'd5, 5'd4, 5'd6, 5'd8,
		5'd13, 5'd5, 5'd8, 5'd6, 5'd3, 5'd4, 5'd5, 5'd4, 5'd3
	};

	localparam logic [8*PREFIX_BYTES-1:0] PREFIX_NAME [NUM_PREFIXES] = '{
		"HTTP/", "EVENT/", "rtsp://", "RTSP/", "HTTP/"
	};
	localparam pos_t PREFIX_LEN [NUM_PREFIXES] = '{5'd5, 5'd6, 5'd7, 5'd5, 5'd5};

	localparam logic [39:0] HLS_DIR   = "/hls/";
	localparam logic [39:0] SUF_M3U8  = ".m3u8";
	localparam logic [31:0] SUF_M3U   = ".m3u";
	localparam logic [23:0] SUF_TS    = ".ts";
	localparam logic [31:0] SUF_M4S   = ".m4s";

	function automatic byte_t fold(input byte_t b);
		return (b >= "A" && b <= "Z") ? byte_t'(b + 8'd32) : b;
	endfunction

	function automatic byte_t method_byte(input int unsigned i, input pos_t pos);
		pos_t k;
		k = pos_t'(METHOD_LEN[i] - 5'd1 - pos);
		return METHOD_NAME[i][k[3:0]*8 +: 8];
	endfunction

	function automatic byte_t prefix_byte(input int unsigned i, input pos_t pos);
		pos_t k;
		k = pos_t'(PREFIX_LEN[i] - 5'd1 - pos);
		return PREFIX_NAME[i][k[2:0]*8 +: 8];
	endfunction

	function automatic byte_t hls_byte(input pos_t pos);
		pos_t k;
		k = pos_t'(5'd4 - pos);
		return HLS_DIR[k[2:0]*8 +: 8];
	endfunction

endpackage
`default_nettype wire

/* rtl/rlpc_in_if.sv */
// Interface: input byte channel of the request line classifier.
`default_nettype none
interface rlpc_in_if import rlpc_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

/* rtl/rlpc_out_if.sv */
// Interface: result channel of the request line classifier.
`default_nettype none
interface rlpc_out_if import rlpc_pkg::*; ();
	logic      valid;
	logic      ready;
	category_t category;
	count_t    token_count;

	modport source (output valid, output category, output token_count, input ready);
	modport sink   (input valid, input category, input token_count, output ready);
endinterface
`default_nettype wire

/* rtl/request_line_protocol_classifier.sv */
// Top level: request line protocol classifier.
//
// Usage:
//   req carries the opening bytes of a connection, one word per byte, with
//   last_byte set on the final byte. res carries one word per connection:
//   category (unknown, http, hls, rtsp, reverse http) and token_count.
//   The first line ends at CR or LF; later bytes are consumed and ignored.
//   Throughput: one byte per cycle, with no gaps between connections, while a last byte is not held by a stalled res.
//   Timing: a byte is held in an input register, where the match flags are
//   updated from it; the result word is then captured in an output register
//   when the input register advances a last byte.
//   The match logic is a set of parallel per-keyword compares against the
//   current token position, so the rate is set by that single stage.
//   When res stalls, the result word holds and the input register keeps
//   its byte only if it is a last byte; other bytes keep flowing.
//   Reset clears all match state and the valid flags of both registers; after each result
//   the match state returns to its reset value for the next connection.
`default_nettype none
module request_line_protocol_classifier import rlpc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rlpc_in_if.sink   req,
	rlpc_out_if.source res
);

	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;
	logic  advance;

	logic      out_valid_q;
	category_t category_q;
	count_t    count_q;

	count_t                   tok_idx_q, tok_idx_d;
	logic                     inside_q, inside_d;
	logic                     active_q, active_d;
	logic                     line_done_q, line_done_d;
	pos_t                     tok_pos_q, tok_pos_d;
	logic [NUM_METHODS-1:0]   method_live_q, method_live_d;
	logic [NUM_PREFIXES-1:0]  prefix_live_q, prefix_live_d;
	logic                     path_ended_q, path_ended_d;
	pos_t                     path_pos_q, path_pos_d;
	logic [1:0]               hls_live_q, hls_live_d;
	logic [8*WINDOW_BYTES-1:0] window_q, window_d;
	logic [NUM_VERDICTS-1:0]  verdicts_q, verdicts_d;
	category_t                category_d;

	byte_t lb;
	logic  is_crlf;
	logic  is_sep;

	assign lb      = fold(byte_s1);
	assign is_crlf = (byte_s1 == CH_CR) || (byte_s1 == CH_LF);
	assign is_sep  = (byte_s1 == CH_SP) || (byte_s1 == CH_TAB) ||
	                 (byte_s1 == CH_VT) || (byte_s1 == CH_FF);

	assign advance   = valid_s1 && (!last_s1 || !out_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	always_comb begin
		tok_idx_d     = tok_idx_q;
		inside_d      = inside_q;
		active_d      = active_q;
		line_done_d   = line_done_q;
		tok_pos_d     = tok_pos_q;
		method_live_d = method_live_q;
		prefix_live_d = prefix_live_q;
		path_ended_d  = path_ended_q;
		path_pos_d    = path_pos_q;
		hls_live_d    = hls_live_q;
		window_d      = window_q;
		verdicts_d    = verdicts_q;
		category_d    = CAT_UNKNOWN;

		if (!line_done_q && !is_crlf && !is_sep) begin
			if (!inside_q) begin
				inside_d      = 1'b1;
				active_d      = tok_idx_q != TOKENS_MAX;
				if (tok_idx_q != TOKENS_MAX) begin
					tok_idx_d = count_t'(tok_idx_q + 2'd1);
				end
				tok_pos_d     = '0;
				method_live_d = '1;
				prefix_live_d = '1;
				path_ended_d  = 1'b0;
				path_pos_d    = '0;
				hls_live_d    = 2'b11;
				window_d      = '0;
			end
			if (active_d) begin
				for (int unsigned i = 0; i < NUM_METHODS; i++) begin
					if (tok_pos_d >= METHOD_LEN[i] || method_byte(i, tok_pos_d) != byte_s1) begin
						method_live_d[i] = 1'b0;
					end
				end
				for (int unsigned i = 0; i < NUM_PREFIXES; i++) begin
					if (tok_pos_d < PREFIX_LEN[i] &&
					    prefix_byte(i, tok_pos_d) != ((i == P_URL_RTSP) ? lb : byte_s1)) begin
						prefix_live_d[i] = 1'b0;
					end
				end
				if (!path_ended_d) begin
					if (byte_s1 == CH_QM || byte_s1 == CH_HASH) begin
						path_ended_d = 1'b1;
					end else begin
						if (path_pos_d < 5'd5 && hls_byte(path_pos_d) != lb) begin
							hls_live_d[0] = 1'b0;
						end
						if (path_pos_d < 5'd4 && hls_byte(path_pos_d) != lb) begin
							hls_live_d[1] = 1'b0;
						end
						window_d = {window_d[8*WINDOW_BYTES-9:0], lb};
						if (path_pos_d != POS_MAX) begin
							path_pos_d = pos_t'(path_pos_d + 5'd1);
						end
					end
				end
				if (tok_pos_d != POS_MAX) begin
					tok_pos_d = pos_t'(tok_pos_d + 5'd1);
				end
			end
		end

		if (!line_done_q && is_crlf) begin
			line_done_d = 1'b1;
		end

		if ((!line_done_q && (is_crlf || is_sep)) || last_s1) begin
			if (inside_d && active_d) begin
				if (tok_idx_d == 2'd1) begin
					for (int unsigned i = 0; i < NUM_METHODS; i++) begin
						if (method_live_d[i] && tok_pos_d == METHOD_LEN[i]) begin
							if (i < NUM_RTSP_METHODS) begin
								verdicts_d[V_RTSP_METHOD] = 1'b1;
							end
							if (HTTP_METHOD_MASK[i]) begin
								verdicts_d[V_HTTP_METHOD] = 1'b1;
							end
						end
					end
					if ((prefix_live_d[P_MTH_HTTP] && tok_pos_d >= PREFIX_LEN[P_MTH_HTTP]) ||
					    (prefix_live_d[P_MTH_EVENT] && tok_pos_d >= PREFIX_LEN[P_MTH_EVENT])) begin
						verdicts_d[V_REVERSE] = 1'b1;
					end
				end else if (tok_idx_d == 2'd2) begin
					if (prefix_live_d[P_URL_RTSP] && tok_pos_d >= PREFIX_LEN[P_URL_RTSP]) begin
						verdicts_d[V_RTSP_URL] = 1'b1;
					end
					if ((hls_live_d[0] && path_pos_d >= 5'd5) ||
					    (hls_live_d[1] && path_pos_d == 5'd4) ||
					    (path_pos_d >= 5'd5 && window_d[39:0] == SUF_M3U8) ||
					    (path_pos_d >= 5'd4 && window_d[31:0] == SUF_M3U) ||
					    (path_pos_d >= 5'd3 && window_d[23:0] == SUF_TS) ||
					    (path_pos_d >= 5'd4 && window_d[31:0] == SUF_M4S)) begin
						verdicts_d[V_HLS] = 1'b1;
					end
				end else begin
					if (prefix_live_d[P_VER_RTSP] && tok_pos_d >= PREFIX_LEN[P_VER_RTSP]) begin
						verdicts_d[V_VER_RTSP] = 1'b1;
					end
					if (prefix_live_d[P_VER_HTTP] && tok_pos_d >= PREFIX_LEN[P_VER_HTTP]) begin
						verdicts_d[V_VER_HTTP] = 1'b1;
					end
				end
			end
			inside_d = 1'b0;
			active_d = 1'b0;
		end

		if (tok_idx_d == TOKENS_MAX) begin
			if (verdicts_d[V_REVERSE]) begin
				category_d = CAT_REVERSE;
			end else if (verdicts_d[V_VER_RTSP] || verdicts_d[V_RTSP_METHOD] ||
			             verdicts_d[V_RTSP_URL]) begin
				category_d = CAT_RTSP;
			end else if (verdicts_d[V_VER_HTTP] || verdicts_d[V_HTTP_METHOD]) begin
				category_d = verdicts_d[V_HLS] ? CAT_HLS : CAT_HTTP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
			last_s1  <= req.last_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			byte_s1 <= req.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_idx_q     <= '0;
			inside_q      <= 1'b0;
			active_q      <= 1'b0;
			line_done_q   <= 1'b0;
			tok_pos_q     <= '0;
			method_live_q <= '0;
			prefix_live_q <= '0;
			path_ended_q  <= 1'b0;
			path_pos_q    <= '0;
			hls_live_q    <= '0;
			window_q      <= '0;
			verdicts_q    <= '0;
		end else if (advance) begin
			if (last_s1) begin
				tok_idx_q     <= '0;
				inside_q      <= 1'b0;
				active_q      <= 1'b0;
				line_done_q   <= 1'b0;
				tok_pos_q     <= '0;
				method_live_q <= '0;
				prefix_live_q <= '0;
				path_ended_q  <= 1'b0;
				path_pos_q    <= '0;
				hls_live_q    <= '0;
				window_q      <= '0;
				verdicts_q    <= '0;
			end else begin
				tok_idx_q     <= tok_idx_d;
				inside_q      <= inside_d;
				active_q      <= active_d;
				line_done_q   <= line_done_d;
				tok_pos_q     <= tok_pos_d;
				method_live_q <= method_live_d;
				prefix_live_q <= prefix_live_d;
				path_ended_q  <= path_ended_d;
				path_pos_q    <= path_pos_d;
				hls_live_q    <= hls_live_d;
				window_q      <= window_d;
				verdicts_q    <= verdicts_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			category_q <= category_d;
			count_q    <= tok_idx_d;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.category    = category_q;
	assign res.token_count = count_q;

endmodule
`default_nettype wire

/* sim/tb.sv */
// Testbench: feeds request lines byte by byte into the classifier and checks each category word.
`default_nettype none
module tb import rlpc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int    CYCLE_LIMIT   = 200000;
	localparam int    RANDOM_BYTES  = 340;
	localparam int    RANDOM_LINES  = 8;
	localparam int    DRAIN_CYCLES  = 8;
	localparam int    MAX_PRINTS    = 40;
	localparam int    OPTIONS_VERB  = 4;
	localparam byte_t NUL_STAND_IN  = 8'h01;

	typedef struct packed {
		category_t category;
		count_t    token_count;
	} line_class_t;

	typedef struct {
		string     text;
		bit        typed;
		category_t category;
		count_t    token_count;
	} probe_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rlpc_in_if  req_if ();
	rlpc_out_if res_if ();

	request_line_protocol_classifier DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.res    (res_if.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	string verb_name [NUM_METHODS] = '{
		"ANNOUNCE", "DESCRIBE", "FLUSH", "GET\137PARAMETER", "OPTIONS", "PAUSE",
		"PLAY", "RECORD", "REDIRECT", "SET\137PARAMETER", "SETUP", "TEARDOWN",
		"DELETE", "GET", "HEAD", "PATCH", "POST", "PUT"
	};
	string lead_name [NUM_PREFIXES] = '{"HTTP/", "EVENT/", "rtsp://", "RTSP/", "HTTP/"};
	string dir_name = "/hls/";

	string head_pick [6] = '{"/hls/", "/hls", "rtsp://", "RTSP://", "/", "/HLS/"};
	string tail_pick [9] = '{".m3u8", ".M3U8", ".m3u", ".ts", ".TS", ".m4s", ".m3", ".s", "/hls"};
	string ver_pick  [9] = '{
		"HTTP/1.1", "HTTP/1.0", "RTSP/1.0", "RTSP/", "HTTP/", "http/1.1", "HTTP", "RTSP/2.0",
		"EVENT/1"
	};
	string end_pick  [4] = '{"\r\n", "\n", "\r", ""};
	byte_t blank_pick [6] = '{CH_SP, CH_SP, CH_SP, CH_TAB, CH_VT, CH_FF};

	probe_t probes [22] = '{
		'{"\n", 1'b1, CAT_UNKNOWN, 2'd0},
		'{"GET /index.html HTTP/1.1\r\n", 1'b1, CAT_HTTP, TOKENS_MAX},
		'{"GET /hls/a HTTP/1.1\r\n", 1'b1, CAT_HLS, TOKENS_MAX},
		'{"GET /live/x.M3U8?t=1 HTTP/1.0\n", 1'b0, CAT_UNKNOWN, 2'd0},
		'{"DESCRIBE rtsp://cam/s RTSP/1.0\r\n", 1'b1, CAT_RTSP, TOKENS_MAX},
		'{"HTTP/1.1 200 OK\r\n", 1'b1, CAT_REVERSE, TOKENS_MAX},
		'{"EVENT/1.0 x y", 1'b1, CAT_REVERSE, TOKENS_MAX},
		'{"GET /a", 1'b1, CAT_UNKNOWN, 2'd2},
		'{"\t\013\014 GET\t/hls\014HTTP/1.1 extra more\r\nPLAY x RTSP/1.0\r\n", 1'b0,
			CAT_UNKNOWN, 2'd0},
		'{"FOO RTSP://X/ HTTP/1.1\n", 1'b0, CAT_UNKNOWN, 2'd0},
		'{"get / http/1.1\r\n", 1'b1, CAT_UNKNOWN, TOKENS_MAX},
		'{"GET\137PARAMETER_AND_A_LONG_NAME_XX /p/q/r/s/t/u/v/w/x/y/z/0/f.ts HTTP/9\r\n",
			1'b0, CAT_UNKNOWN, 2'd0},
		'{"SET\137PARAMETER * RTSP/1.0\r\n", 1'b0, CAT_UNKNOWN, 2'd0},
		'{"POST /seg.m4s#frag HTTP/2\r\n", 1'b0, CAT_UNKNOWN, 2'd0},
		'{"PUT /a.ts?x.m3u HTTP/1.1\r\n", 1'b0, CAT_UNKNOWN, 2'd0},
		'{"HEAD /hlsx HTTP/1.1\r\n", 1'b0, CAT_UNKNOWN, 2'd0},
		'{"\001\377 \377\001 \001\n", 1'b1, CAT_UNKNOWN, TOKENS_MAX},
		'{"\rGET / HTTP/1.1", 1'b1, CAT_UNKNOWN, 2'd0},
		'{"GETX /x.ts RTSP/1.0", 1'b0, CAT_UNKNOWN, 2'd0},
		'{"PATCH /.m3u HTTP/1.1\r\n", 1'b0, CAT_UNKNOWN, 2'd0},
		'{"OPTIONS * RTSP/1.0\r\n\r\nxyz", 1'b0, CAT_UNKNOWN, 2'd0},
		'{"TEARDOWN a b c d e f\n", 1'b1, CAT_RTSP, TOKENS_MAX}
	};

	// Line classification state
	count_t              tok_idx;
	bit                  in_tok;
	bit                  tok_open;
	bit                  line_done;
	pos_t                tok_pos;
	logic [NUM_METHODS-1:0]  verb_live;
	logic [NUM_PREFIXES-1:0] lead_live;
	bit                  path_done;
	pos_t                path_pos;
	logic [1:0]          dir_live;
	logic [39:0]         tail_win;
	logic [NUM_VERDICTS-1:0] facts;

	line_class_t pending_class [$];
	byte_t       line_buf [$];

	int faults;
	int bytes_sent;
	int lines_sent;
	int results_seen;
	int class_seen [8];
	int burst_left;
	int tick;
	int sink_mode;

	task automatic note_fault(input string what);
		if (faults < MAX_PRINTS)
			$display("%0t ns: %s", $time, what);
		faults++;
	endtask

	function automatic byte_t lower_byte(input byte_t c);
		return (c >= "A" && c <= "Z") ? byte_t'(c + 8'd32) : c;
	endfunction

	function automatic bit is_blank(input byte_t c);
		return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF;
	endfunction

	function automatic bit lead_hit(input int i);
		return lead_live[i] && tok_pos >= lead_name[i].len();
	endfunction

	function automatic bit tail_is(input string s);
		int n;
		n = s.len();
		if (path_pos < n)
			return 1'b0;
		for (int k = 0; k < n; k++)
			if (tail_win[8*(n-1-k) +: 8] != byte_t'(s[k]))
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic clear_line_state;
		tok_idx = '0;
		in_tok = 1'b0;
		tok_open = 1'b0;
		line_done = 1'b0;
		tok_pos = '0;
		verb_live = '0;
		lead_live = '0;
		path_done = 1'b0;
		path_pos = '0;
		dir_live = '0;
		tail_win = '0;
		facts = '0;
	endtask

	task automatic open_token;
		in_tok = 1'b1;
		tok_open = tok_idx < TOKENS_MAX;
		if (tok_idx < TOKENS_MAX)
			tok_idx++;
		tok_pos = '0;
		verb_live = '1;
		lead_live = '1;
		path_done = 1'b0;
		path_pos = '0;
		dir_live = 2'b11;
		tail_win = '0;
	endtask

	task automatic absorb(input byte_t b);
		byte_t lb;
		byte_t c;
		lb = lower_byte(b);
		for (int i = 0; i < NUM_METHODS; i++)
			if (tok_pos >= verb_name[i].len() || byte_t'(verb_name[i][tok_pos]) != b)
				verb_live[i] = 1'b0;
		for (int i = 0; i < NUM_PREFIXES; i++) begin
			c = (i == P_URL_RTSP) ? lb : b;
			if (tok_pos < lead_name[i].len() && byte_t'(lead_name[i][tok_pos]) != c)
				lead_live[i] = 1'b0;
		end
		if (!path_done) begin
			if (b == CH_QM || b == CH_HASH) begin
				path_done = 1'b1;
			end else begin
				if (path_pos < 5 && byte_t'(dir_name[path_pos]) != lb)
					dir_live[0] = 1'b0;
				if (path_pos < 4 && byte_t'(dir_name[path_pos]) != lb)
					dir_live[1] = 1'b0;
				tail_win = {tail_win[31:0], lb};
				if (path_pos < POS_MAX)
					path_pos++;
			end
		end
		if (tok_pos < POS_MAX)
			tok_pos++;
	endtask

	task automatic close_token;
		if (in_tok && tok_open) begin
			case (tok_idx)
			2'd1: begin
				for (int i = 0; i < NUM_METHODS; i++)
					if (verb_live[i] && tok_pos == verb_name[i].len()) begin
						if (i < NUM_RTSP_METHODS)
							facts[V_RTSP_METHOD] = 1'b1;
						if (i == OPTIONS_VERB || i >= NUM_RTSP_METHODS)
							facts[V_HTTP_METHOD] = 1'b1;
					end
				if (lead_hit(P_MTH_HTTP) || lead_hit(P_MTH_EVENT))
					facts[V_REVERSE] = 1'b1;
			end
			2'd2: begin
				if (lead_hit(P_URL_RTSP))
					facts[V_RTSP_URL] = 1'b1;
				if ((dir_live[0] && path_pos >= 5) || (dir_live[1] && path_pos == 4) ||
						tail_is(".m3u8") || tail_is(".m3u") || tail_is(".ts") ||
						tail_is(".m4s"))
					facts[V_HLS] = 1'b1;
			end
			default: begin
				if (lead_hit(P_VER_RTSP))
					facts[V_VER_RTSP] = 1'b1;
				if (lead_hit(P_VER_HTTP))
					facts[V_VER_HTTP] = 1'b1;
			end
			endcase
		end
		in_tok = 1'b0;
		tok_open = 1'b0;
	endtask

	task automatic classify_byte(input byte_t b, input bit lst, output bit emits,
			output line_class_t verdict);
		category_t cat;
		if (!line_done) begin
			if (b == CH_CR || b == CH_LF) begin
				close_token();
				line_done = 1'b1;
			end else if (is_blank(b)) begin
				close_token();
			end else begin
				if (!in_tok)
					open_token();
				if (tok_open)
					absorb(b);
			end
		end
		emits = lst;
		verdict = '0;
		if (lst) begin
			close_token();
			cat = CAT_UNKNOWN;
			if (tok_idx == TOKENS_MAX) begin
				if (facts[V_REVERSE])
					cat = CAT_REVERSE;
				else if (facts[V_VER_RTSP] || facts[V_RTSP_METHOD] || facts[V_RTSP_URL])
					cat = CAT_RTSP;
				else if (facts[V_VER_HTTP] || facts[V_HTTP_METHOD])
					cat = facts[V_HLS] ? CAT_HLS : CAT_HTTP;
			end
			verdict.category = cat;
			verdict.token_count = tok_idx;
			clear_line_state();
		end
	endtask

	task automatic send_word(input byte_t b, input logic lst);
		req_if.valid <= 1'b1;
		req_if.data_byte <= b;
		req_if.last_byte <= lst;
		do @(posedge clk); while (req_if.ready !== 1'b1);
	endtask

	task automatic pace;
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 3);
		req_if.valid <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic send_line(input bit typed, input line_class_t fixed);
		bit          emits;
		bit          lst;
		line_class_t verdict;
		for (int k = 0; k < line_buf.size(); k++) begin
			lst = (k == line_buf.size() - 1);
			send_word(line_buf[k], lst);
			classify_byte(line_buf[k], lst, emits, verdict);
			if (emits)
				pending_class.insert(pending_class.size(), typed ? fixed : verdict);
			bytes_sent++;
			pace();
		end
		lines_sent++;
	endtask

	task automatic add_text(input string s);
		for (int k = 0; k < s.len(); k++)
			line_buf.insert(line_buf.size(), byte_t'(s[k]));
	endtask

	task automatic add_chars(input int lo, input int hi, input bit any);
		int n;
		n = $urandom_range(lo, hi);
		repeat (n)
			line_buf.insert(line_buf.size(), any ? byte_t'($urandom_range(0, 255)) :
				byte_t'($urandom_range(33, 126)));
	endtask

	task automatic add_blanks;
		int n;
		n = $urandom_range(1, 3);
		repeat (n)
			line_buf.insert(line_buf.size(), blank_pick[$urandom_range(0, 5)]);
	endtask

	task automatic build_request;
		int kind;
		int keep;
		kind = $urandom_range(0, 7);
		line_buf.delete();
		if (kind == 0) begin
			add_chars(1, 30, 1'b1);
			return;
		end
		if ($urandom_range(0, 5) == 0)
			add_blanks();
		case ($urandom_range(0, 9))
		0, 1, 2, 3, 4, 5: add_text(verb_name[$urandom_range(0, NUM_METHODS - 1)]);
		6: add_text("HTTP/1.1");
		7: add_text("EVENT/1.0");
		8: begin
			add_text(verb_name[$urandom_range(0, NUM_METHODS - 1)]);
			add_chars(1, 2, 1'b0);
		end
		default: add_chars(1, 10, 1'b0);
		endcase
		add_blanks();
		if ($urandom_range(0, 4) != 0)
			add_text(head_pick[$urandom_range(0, 5)]);
		add_chars(0, ($urandom_range(0, 7) == 0) ? 40 : 8, 1'b0);
		if ($urandom_range(0, 2) != 0)
			add_text(tail_pick[$urandom_range(0, 8)]);
		if ($urandom_range(0, 3) == 0) begin
			add_text($urandom_range(0, 1) ? "?" : "#");
			add_chars(0, 6, 1'b0);
		end
		add_blanks();
		add_text(ver_pick[$urandom_range(0, 8)]);
		if ($urandom_range(0, 3) == 0) begin
			add_blanks();
			add_chars(1, 5, 1'b0);
		end
		add_text(end_pick[$urandom_range(0, 3)]);
		add_chars(0, 6, 1'b1);
		if (kind == 1) begin
			keep = $urandom_range(1, line_buf.size());
			while (line_buf.size() > keep)
				void'(line_buf.pop_back());
		end
	endtask

	always @(posedge clk) begin
		tick <= tick + 1;
		if (tick == CYCLE_LIMIT) begin
			$display("request_line_protocol_classifier: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (tick % 128 == 0)
			sink_mode = $urandom_range(0, 3);
		case (sink_mode)
		0: res_if.ready <= 1'b1;
		1: res_if.ready <= 1'($urandom_range(0, 1));
		2: res_if.ready <= (tick % 8) >= 3;
		default: res_if.ready <= (tick % 16) == 0;
		endcase
	end

	always @(posedge clk) begin
		line_class_t want;
		if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
			if (pending_class.size() == 0) begin
				note_fault($sformatf("unexpected word: category %0d, token_count %0d",
					res_if.category, res_if.token_count));
			end else begin
				want = pending_class.pop_front();
				results_seen++;
				class_seen[res_if.category]++;
				if (res_if.category !== want.category)
					note_fault($sformatf("category %0d, predicted %0d",
						res_if.category, want.category));
				if (res_if.token_count !== want.token_count)
					note_fault($sformatf("token_count %0d, predicted %0d",
						res_if.token_count, want.token_count));
			end
		end
	end

	initial begin
		int base_bytes;
		int base_lines;
		req_if.valid <= 1'b0;
		req_if.data_byte <= '0;
		req_if.last_byte <= 1'b0;
		clear_line_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			line_buf.delete();
			add_text(probes[i].text);
			foreach (line_buf[k])
				if (line_buf[k] == NUL_STAND_IN)
					line_buf[k] = 8'h00;
			send_line(probes[i].typed,
				line_class_t'{probes[i].category, probes[i].token_count});
		end

		base_bytes = bytes_sent;
		base_lines = lines_sent;
		while (bytes_sent - base_bytes < RANDOM_BYTES || lines_sent - base_lines < RANDOM_LINES)
		begin
			build_request();
			send_line(1'b0, '0);
		end
		req_if.valid <= 1'b0;

		while (pending_class.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d request lines, %0d bytes sent; %0d category words compared, %0d faults",
			lines_sent, bytes_sent, results_seen, faults);
		$display("words by category: unknown %0d, http %0d, hls %0d, rtsp %0d, reverse %0d",
			class_seen[CAT_UNKNOWN], class_seen[CAT_HTTP], class_seen[CAT_HLS],
			class_seen[CAT_RTSP], class_seen[CAT_REVERSE]);
		if (faults == 0 && pending_class.size() == 0)
			$display("request_line_protocol_classifier: match");
		else
			$display("request_line_protocol_classifier: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
